// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RTN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define RTN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rtn_pkg.sv -----
// Package with the operation codes, register indexes and reset values of the root election node.
package rtn_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_ADVERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_NODE_ID      = 3'd0;
  localparam logic [2:0] REG_EXPIRY_TICKS = 3'd1;
  localparam logic [2:0] REG_HELLO_PERIOD = 3'd2;
  localparam logic [2:0] REG_LINK_COUNT   = 3'd3;
  localparam logic [2:0] REG_COST_BASE    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_NODE_ID      = 32'd0;
  localparam logic [31:0] RST_EXPIRY_TICKS = 32'd1000;
  localparam logic [31:0] RST_HELLO_PERIOD = 32'd1000;
  localparam logic [2:0]  RST_LINK_COUNT   = 3'd1;
  localparam logic [31:0] RST_LINK_COST    = 32'd1;

endpackage

// ----- src/root_election_node.sv -----
// Top level of one node of a distance-vector root election.
//
// Input channel: one transaction is either a received advertisement
// (in_operation low, with link, root and cost) or one time tick
// (in_operation high). Each transaction yields exactly one result on the
// output channel, carrying the send flag, the current root, cost and parent,
// and whether the state changed.
// Path: an accepted input is held in the input register and then moves into
// the result register, where out_valid rises with its result.
// Throughput: one transaction per cycle while no result is stalled; the whole
// decision (one 32-bit add and compares, or the timer decrements) sits between
// the input register and the result register.
// Stall: while out_stall holds a result, one more input is taken into the
// input register; in_stall rises only when both registers are full.
// Reset: rst_n is synchronous and active low. It loads the configuration
// defaults, makes the node its own root and clears both timers, so the first
// tick sends the initial announcement.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user must
// write it only while no transaction is in flight, which the block does not enforce.
module root_election_node #(
  parameter int MAX_LINKS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_link,
  input  logic [31:0] in_rx_root,
  input  logic [31:0] in_rx_cost,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_advert,
  output logic [31:0] out_adv_root,
  output logic [31:0] out_adv_cost,
  output logic        out_parent_valid,
  output logic [1:0]  out_parent_link,
  output logic        out_state_changed
);

  localparam logic [7:0] MaxLinksW = 8'(MAX_LINKS);

  // Configuration registers.
  logic [31:0] node_id_r;
  logic [31:0] expiry_ticks_r;
  logic [31:0] hello_period_r;
  logic [2:0]  link_count_r;
  logic [31:0] link_cost_r [MAX_LINKS];

  // Election state.
  logic        self_is_root_r, self_is_root_nxt;
  logic [31:0] learned_root_r, learned_root_nxt;
  logic [31:0] path_cost_r, path_cost_nxt;
  logic [1:0]  parent_index_r, parent_index_nxt;
  logic [31:0] root_cnt_r, root_cnt_nxt;
  logic [31:0] hello_cnt_r, hello_cnt_nxt;

  // Input register.
  logic        in_valid_r;
  logic        in_operation_r;
  logic [7:0]  in_rx_link_r;
  logic [31:0] in_rx_root_r;
  logic [31:0] in_rx_cost_r;

  // Result register.
  logic        out_valid_r;
  logic        send_nxt, changed_nxt;
  logic        out_send_advert_r;
  logic [31:0] out_adv_root_r;
  logic [31:0] out_adv_cost_r;
  logic        out_parent_valid_r;
  logic [1:0]  out_parent_link_r;
  logic        out_state_changed_r;

  // Decision signals.
  logic        advance;
  logic [31:0] cur_root;
  logic [31:0] sel_cost;
  logic [31:0] offer_cost;
  logic        link_ok;
  logic [31:0] root_dec;
  logic [31:0] hello_dec;

  // Handshake: the result register moves when empty or taken downstream.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r      <= rtn_pkg::RST_NODE_ID;
      expiry_ticks_r <= rtn_pkg::RST_EXPIRY_TICKS;
      hello_period_r <= rtn_pkg::RST_HELLO_PERIOD;
      link_count_r   <= rtn_pkg::RST_LINK_COUNT;
      for (int i = 0; i < MAX_LINKS; i++) begin
        link_cost_r[i] <= rtn_pkg::RST_LINK_COST;
      end
    end else if (cfg_we) begin
      if (cfg_index == rtn_pkg::REG_NODE_ID) begin
        node_id_r <= cfg_wdata;
      end
      if (cfg_index == rtn_pkg::REG_EXPIRY_TICKS) begin
        expiry_ticks_r <= cfg_wdata;
      end
      if (cfg_index == rtn_pkg::REG_HELLO_PERIOD) begin
        hello_period_r <= cfg_wdata;
      end
      if (cfg_index == rtn_pkg::REG_LINK_COUNT) begin
        link_count_r <= cfg_wdata[2:0];
      end
      for (int i = 0; i < MAX_LINKS; i++) begin
        if (cfg_index == rtn_pkg::REG_COST_BASE + 3'(i)) begin
          link_cost_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Input register: takes a new transaction whenever it is not stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_operation_r <= in_operation;
      in_rx_link_r   <= in_rx_link;
      in_rx_root_r   <= in_rx_root;
      in_rx_cost_r   <= in_rx_cost;
    end
  end

  // Cost of the arrival link and the resulting path cost.
  always_comb begin
    sel_cost = '0;
    for (int i = 0; i < MAX_LINKS; i++) begin
      if (in_rx_link_r[1:0] == 2'(i)) begin
        sel_cost = link_cost_r[i];
      end
    end
  end

  assign offer_cost = in_rx_cost_r + sel_cost;
  assign cur_root   = self_is_root_r ? node_id_r : learned_root_r;
  assign link_ok    = (in_rx_link_r < {5'd0, link_count_r}) && (in_rx_link_r < MaxLinksW);

  // Saturating timer decrements for a tick.
  assign root_dec  = (root_cnt_r != '0) ? root_cnt_r - 32'd1 : '0;
  assign hello_dec = (hello_cnt_r != '0) ? hello_cnt_r - 32'd1 : '0;

  // Election decision for the transaction in the input register.
  always_comb begin
    self_is_root_nxt = self_is_root_r;
    learned_root_nxt = learned_root_r;
    path_cost_nxt    = path_cost_r;
    parent_index_nxt = parent_index_r;
    root_cnt_nxt     = root_cnt_r;
    hello_cnt_nxt    = hello_cnt_r;
    changed_nxt      = 1'b0;
    send_nxt         = 1'b0;
    if (in_operation_r == rtn_pkg::OP_ADVERT) begin
      // Echoes of the own root and links out of range are ignored.
      if (link_ok && !(self_is_root_r && in_rx_root_r == node_id_r)) begin
        priority if (in_rx_root_r < cur_root) begin
          // A lower root is adopted through the arrival link.
          self_is_root_nxt = 1'b0;
          learned_root_nxt = in_rx_root_r;
          path_cost_nxt    = offer_cost;
          parent_index_nxt = in_rx_link_r[1:0];
          root_cnt_nxt     = expiry_ticks_r;
          changed_nxt      = 1'b1;
        end else if (in_rx_root_r != cur_root || self_is_root_r) begin
          changed_nxt = 1'b0;
        end else if (in_rx_link_r[1:0] == parent_index_r) begin
          // The parent refreshes the timer and sets the cost.
          root_cnt_nxt  = expiry_ticks_r;
          path_cost_nxt = offer_cost;
          changed_nxt   = (offer_cost != path_cost_r);
        end else if (offer_cost < path_cost_r) begin
          // A strictly cheaper path moves the parent.
          path_cost_nxt    = offer_cost;
          parent_index_nxt = in_rx_link_r[1:0];
          root_cnt_nxt     = expiry_ticks_r;
          changed_nxt      = 1'b1;
        end else begin
          // Another neighbor without a cheaper path changes nothing.
          changed_nxt = 1'b0;
        end
      end
      if (changed_nxt) begin
        send_nxt      = 1'b1;
        hello_cnt_nxt = hello_period_r;
      end
    end else begin
      root_cnt_nxt  = root_dec;
      hello_cnt_nxt = hello_dec;
      priority if (!self_is_root_r && root_dec == '0) begin
        // The learned root expired: the node becomes its own root again.
        self_is_root_nxt = 1'b1;
        path_cost_nxt    = '0;
        parent_index_nxt = '0;
        root_cnt_nxt     = expiry_ticks_r;
        hello_cnt_nxt    = hello_period_r;
        changed_nxt      = 1'b1;
        send_nxt         = 1'b1;
      end else if (hello_dec == '0) begin
        hello_cnt_nxt = hello_period_r;
        send_nxt      = 1'b1;
      end else begin
        // Neither the learned root expired nor the hello timer ran out on this tick.
        send_nxt = 1'b0;
      end
    end
  end

  // State update when the transaction moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_is_root_r <= 1'b1;
      learned_root_r <= '0;
      path_cost_r    <= '0;
      parent_index_r <= '0;
      root_cnt_r     <= '0;
      hello_cnt_r    <= '0;
    end else if (in_valid_r && advance) begin
      self_is_root_r <= self_is_root_nxt;
      learned_root_r <= learned_root_nxt;
      path_cost_r    <= path_cost_nxt;
      parent_index_r <= parent_index_nxt;
      root_cnt_r     <= root_cnt_nxt;
      hello_cnt_r    <= hello_cnt_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_send_advert_r   <= send_nxt;
      out_adv_root_r      <= self_is_root_nxt ? node_id_r : learned_root_nxt;
      out_adv_cost_r      <= path_cost_nxt;
      out_parent_valid_r  <= !self_is_root_nxt;
      out_parent_link_r   <= self_is_root_nxt ? 2'd0 : parent_index_nxt;
      out_state_changed_r <= changed_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_advert   = out_send_advert_r;
  assign out_adv_root      = out_adv_root_r;
  assign out_adv_cost      = out_adv_cost_r;
  assign out_parent_valid  = out_parent_valid_r;
  assign out_parent_link   = out_parent_link_r;
  assign out_state_changed = out_state_changed_r;

endmodule

// ----- src/rtn_checker.sv -----
// Port-level checker of the root election node and its bind statement.
`include "assert_macros.svh"

module rtn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_send_advert,
  input logic [31:0] out_adv_root,
  input logic [31:0] out_adv_cost,
  input logic        out_parent_valid,
  input logic [1:0]  out_parent_link,
  input logic        out_state_changed
);

  // A stalled result transaction stays in place.
  `RTN_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_adv_root) && $stable(out_adv_cost) && $stable(out_send_advert), "stalled result changed")

  // Without a parent the node reports zero cost on link zero.
  `RTN_ASSERT(a_own_root, clk, rst_n, out_valid && !out_parent_valid |-> out_adv_cost == 32'd0 && out_parent_link == 2'd0, "own root with cost or parent link")

  // Every change of root, cost or parent is announced.
  `RTN_ASSERT(a_change_sends, clk, rst_n, out_valid && out_state_changed |-> out_send_advert, "state change without advertisement")

  // Reset empties the result register.
  `RTN_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind root_election_node rtn_checker u_rtn_checker (.*);

// ----- tb/sv/root_election_node_tb.sv -----
// Self-checking testbench for root_election_node: directed cases, then random traffic.
module root_election_node_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINKS    = 4;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  // One result transaction of the node.
  typedef struct packed {
    logic        send_advert;
    logic [31:0] adv_root;
    logic [31:0] adv_cost;
    logic        parent_valid;
    logic [1:0]  parent_link;
    logic        state_changed;
  } node_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = rtn_pkg::OP_TICK;
  logic [7:0]  in_rx_link = '0;
  logic [31:0] in_rx_root = '0;
  logic [31:0] in_rx_cost = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_send_advert;
  logic [31:0] out_adv_root;
  logic [31:0] out_adv_cost;
  logic        out_parent_valid;
  logic [1:0]  out_parent_link;
  logic        out_state_changed;

  root_election_node #(.MAX_LINKS(MAX_LINKS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_rx_link        (in_rx_link),
    .in_rx_root        (in_rx_root),
    .in_rx_cost        (in_rx_cost),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_advert   (out_send_advert),
    .out_adv_root      (out_adv_root),
    .out_adv_cost      (out_adv_cost),
    .out_parent_valid  (out_parent_valid),
    .out_parent_link   (out_parent_link),
    .out_state_changed (out_state_changed)
  );

  // Shadow copy of the configuration registers.
  logic [31:0] node_id_cfg;
  logic [31:0] expiry_ticks;
  logic [31:0] hello_period;
  logic [2:0]  link_cnt;
  logic [31:0] link_cost [MAX_LINKS];

  // Predicted election state.
  logic        is_own_root;
  logic [31:0] learned_root;
  logic [31:0] path_cost;
  logic [1:0]  parent_idx;
  logic [31:0] root_cnt;
  logic [31:0] hello_cnt;

  node_status_t status_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int items_sent     = 0;
  int results_checked = 0;
  int adverts_predicted = 0;
  int topology_changes  = 0;
  int root_expiries     = 0;
  int cycle_count       = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Global watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, status_due.size());
      $display("root_election_node_tb failed");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void reset_election_state();
    node_id_cfg  = rtn_pkg::RST_NODE_ID;
    expiry_ticks = rtn_pkg::RST_EXPIRY_TICKS;
    hello_period = rtn_pkg::RST_HELLO_PERIOD;
    link_cnt     = rtn_pkg::RST_LINK_COUNT;
    for (int i = 0; i < MAX_LINKS; i++) begin
      link_cost[i] = rtn_pkg::RST_LINK_COST;
    end
    is_own_root  = 1'b1;
    learned_root = '0;
    path_cost    = '0;
    parent_idx   = '0;
    root_cnt     = '0;
    hello_cnt    = '0;
  endfunction

  // Handles a received advertisement; returns 1 when root, cost or parent changed.
  function automatic bit absorb_advert(input logic [7:0] link, input logic [31:0] rroot,
                                       input logic [31:0] rcost);
    logic [31:0] via;
    logic [31:0] cur;
    cur = is_own_root ? node_id_cfg : learned_root;
    if (link >= {5'd0, link_cnt} || link >= MAX_LINKS) return 1'b0;
    if (is_own_root && rroot == node_id_cfg) return 1'b0;
    via = rcost + link_cost[link[1:0]];
    // A lower root always wins, whatever the cost.
    if (rroot < cur) begin
      is_own_root  = 1'b0;
      learned_root = rroot;
      path_cost    = via;
      parent_idx   = link[1:0];
      root_cnt     = expiry_ticks;
      return 1'b1;
    end
    if (rroot != cur || is_own_root) return 1'b0;
    // The current parent refreshes the timer and dictates the cost.
    if (link[1:0] == parent_idx) begin
      root_cnt = expiry_ticks;
      if (via != path_cost) begin
        path_cost = via;
        return 1'b1;
      end
      return 1'b0;
    end
    // Another neighbor takes over only on a strictly shorter path.
    if (via < path_cost) begin
      path_cost  = via;
      parent_idx = link[1:0];
      root_cnt   = expiry_ticks;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the predicted node by one transaction and returns its status.
  function automatic node_status_t elect_step(input logic op, input logic [7:0] link,
                                              input logic [31:0] rroot,
                                              input logic [31:0] rcost);
    node_status_t st;
    bit changed;
    bit send;
    changed = 1'b0;
    send    = 1'b0;
    if (op == rtn_pkg::OP_ADVERT) begin
      changed = absorb_advert(link, rroot, rcost);
      if (changed) begin
        send      = 1'b1;
        hello_cnt = hello_period;
      end
    end else begin
      if (root_cnt != 0) root_cnt--;
      if (hello_cnt != 0) hello_cnt--;
      if (!is_own_root && root_cnt == 0) begin
        is_own_root = 1'b1;
        path_cost   = '0;
        parent_idx  = '0;
        root_cnt    = expiry_ticks;
        hello_cnt   = hello_period;
        changed     = 1'b1;
        send        = 1'b1;
        root_expiries++;
      end else if (hello_cnt == 0) begin
        hello_cnt = hello_period;
        send      = 1'b1;
      end
    end
    if (send) adverts_predicted++;
    if (changed) topology_changes++;
    st.send_advert   = send;
    st.adv_root      = is_own_root ? node_id_cfg : learned_root;
    st.adv_cost      = path_cost;
    st.parent_valid  = !is_own_root;
    st.parent_link   = is_own_root ? 2'd0 : parent_idx;
    st.state_changed = changed;
    return st;
  endfunction

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    node_status_t got;
    node_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_send_advert, out_adv_root, out_adv_cost, out_parent_valid,
              out_parent_link, out_state_changed};
      if (status_due.size() == 0) begin
        note_failure($sformatf("result with nothing pending: root=%h cost=%h",
                               got.adv_root, got.adv_cost));
      end else begin
        want = status_due.pop_front();
        results_checked++;
        if (got.send_advert !== want.send_advert || got.adv_root !== want.adv_root ||
            got.adv_cost !== want.adv_cost || got.parent_valid !== want.parent_valid ||
            got.parent_link !== want.parent_link ||
            got.state_changed !== want.state_changed) begin
          note_failure($sformatf({"mismatch: exp send=%0b root=%h cost=%h pv=%0b pl=%0d ",
                                  "chg=%0b, got send=%0b root=%h cost=%h pv=%0b pl=%0d ",
                                  "chg=%0b"},
            want.send_advert, want.adv_root, want.adv_cost, want.parent_valid,
            want.parent_link, want.state_changed, got.send_advert, got.adv_root,
            got.adv_cost, got.parent_valid, got.parent_link, got.state_changed));
        end
      end
    end
  end

  // Sends one input transaction and records its prediction once accepted.
  task automatic send_item(input logic op, input logic [7:0] link,
                           input logic [31:0] rroot, input logic [31:0] rcost);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_link   <= link;
    in_rx_root   <= rroot;
    in_rx_cost   <= rcost;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_due.push_back(elect_step(op, link, rroot, rcost));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(rtn_pkg::OP_TICK, 8'($urandom), $urandom, $urandom);
  endtask

  // Stops sending and waits until every pending result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      rtn_pkg::REG_NODE_ID:      node_id_cfg  = value;
      rtn_pkg::REG_EXPIRY_TICKS: expiry_ticks = value;
      rtn_pkg::REG_HELLO_PERIOD: hello_period = value;
      rtn_pkg::REG_LINK_COUNT:   link_cnt     = value[2:0];
      default:                   link_cost[2'(idx - rtn_pkg::REG_COST_BASE)] = value;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_node(input logic [31:0] node, input logic [31:0] timeout,
                              input logic [31:0] hello, input logic [31:0] links,
                              input logic [31:0] c0, input logic [31:0] c1,
                              input logic [31:0] c2, input logic [31:0] c3);
    wait_drained();
    write_reg(rtn_pkg::REG_NODE_ID, node);
    write_reg(rtn_pkg::REG_EXPIRY_TICKS, timeout);
    write_reg(rtn_pkg::REG_HELLO_PERIOD, hello);
    write_reg(rtn_pkg::REG_LINK_COUNT, links);
    write_reg(rtn_pkg::REG_COST_BASE, c0);
    write_reg(rtn_pkg::REG_COST_BASE + 3'd1, c1);
    write_reg(rtn_pkg::REG_COST_BASE + 3'd2, c2);
    write_reg(rtn_pkg::REG_COST_BASE + 3'd3, c3);
  endtask

  // Defaults after reset: initial announcement, own-root echo, link beyond count.
  task automatic test_reset_announce();
    send_tick();
    send_item(rtn_pkg::OP_ADVERT, 8'd0, 32'd0, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd1, 32'd5, 32'd0);
  endtask

  // Root adoption, parent switching, cost wrap and ignored messages.
  task automatic test_root_adoption();
    program_node(32'h8000_0000, 32'd3, 32'd2, 32'd4,
                 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd1);
    send_item(rtn_pkg::OP_ADVERT, 8'd0, 32'd100, 32'hFFFF_FFFF);
    send_item(rtn_pkg::OP_ADVERT, 8'd1, 32'd100, 32'd2);
    send_item(rtn_pkg::OP_ADVERT, 8'd1, 32'd100, 32'd7);
    send_item(rtn_pkg::OP_ADVERT, 8'd1, 32'd100, 32'd7);
    send_item(rtn_pkg::OP_ADVERT, 8'd2, 32'd100, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd3, 32'd100, 32'd4);
    send_item(rtn_pkg::OP_ADVERT, 8'd3, 32'd200, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd255, 32'd0, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd4, 32'd0, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd0, 32'd0, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Timer countdown, hello expiry and loss of the learned root.
  task automatic test_root_expiry();
    repeat (4) send_tick();
    send_item(rtn_pkg::OP_ADVERT, 8'd0, 32'h8000_0000, 32'd0);
  endtask

  // Zero timers, zero and oversized link counts, node id rewrite, largest timers.
  task automatic test_degenerate_config();
    program_node(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd4, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd0, 32'd1, 32'd0);
    send_tick();
    send_tick();
    wait_drained();
    write_reg(rtn_pkg::REG_LINK_COUNT, 32'd0);
    send_item(rtn_pkg::OP_ADVERT, 8'd0, 32'd0, 32'd0);
    wait_drained();
    write_reg(rtn_pkg::REG_LINK_COUNT, 32'd7);
    send_item(rtn_pkg::OP_ADVERT, 8'd5, 32'd0, 32'd0);
    wait_drained();
    write_reg(rtn_pkg::REG_NODE_ID, 32'h0000_1234);
    write_reg(rtn_pkg::REG_EXPIRY_TICKS, 32'hFFFF_FFFF);
    write_reg(rtn_pkg::REG_HELLO_PERIOD, 32'hFFFF_FFFF);
    send_tick();
    send_item(rtn_pkg::OP_ADVERT, 8'd3, 32'd0, 32'hFFFF_FFFF);
    send_tick();
  endtask

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(9))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom;
      default: return 32'($urandom_range(10));
    endcase
  endfunction

  // Random configuration, weighted toward short timers so expiry happens often.
  task automatic program_random_node();
    logic [31:0] node;
    logic [31:0] timeout;
    logic [31:0] hello;
    logic [31:0] links;
    case ($urandom_range(5))
      0:       node = 32'd0;
      1:       node = 32'hFFFF_FFFF;
      default: node = 32'($urandom_range(10, 40));
    endcase
    case ($urandom_range(19))
      0:       timeout = 32'd0;
      1:       timeout = $urandom;
      default: timeout = 32'($urandom_range(1, 12));
    endcase
    case ($urandom_range(19))
      0:       hello = 32'd0;
      1:       hello = $urandom;
      default: hello = 32'($urandom_range(1, 8));
    endcase
    links = ($urandom_range(9) == 0) ? 32'($urandom_range(7)) : 32'($urandom_range(1, 4));
    program_node(node, timeout, hello, links, pick_cost(), pick_cost(),
                 pick_cost(), pick_cost());
  endtask

  // Mostly plausible neighbor traffic around this node's id, plus noise.
  task automatic send_random_item();
    int pick;
    logic [7:0] link;
    logic [31:0] rroot;
    logic [31:0] rcost;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_tick();
    end else begin
      link  = (pick < 90) ? 8'($urandom_range(3)) : 8'($urandom);
      rroot = (pick < 85) ? node_id_cfg + 32'($urandom_range(8)) - 32'd4 : $urandom;
      rcost = pick_cost();
      send_item(rtn_pkg::OP_ADVERT, link, rroot, rcost);
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    wait_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (3) begin
      program_random_node();
      repeat (100) send_random_item();
    end
  endtask

  initial begin
    reset_election_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 37;
    recv_stall_pct = 61;
    test_reset_announce();
    test_root_adoption();
    test_root_expiry();
    test_degenerate_config();

    test_random_traffic(37, 61);
    test_random_traffic(61, 37);
    test_random_traffic(0, 0);

    wait_drained();
    if (status_due.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", status_due.size()));
    end
    $display("Ran %0d transactions over %0d cycles; %0d results checked.",
             items_sent, cycle_count, results_checked);
    $display("Seen %0d adverts sent, %0d topology changes, %0d root expiries; %0d failures.",
             adverts_predicted, topology_changes, root_expiries, fail_count);
    if (fail_count == 0) begin
      $display("root_election_node_tb passed");
    end else begin
      $display("root_election_node_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/rtn_pkg.sv
src/root_election_node.sv
src/rtn_checker.sv
tb/sv/root_election_node_tb.sv
